>>> rtl/vas_pkg.sv
// Shared constants, opcodes and control types of the voice allocator.
package vas_pkg;

  // Default sizes handed to the top level
  localparam int NUM_CHANNELS_DEF  = 8;
  localparam int SOUND_ID_BITS_DEF = 8;

  // Fixed field widths
  localparam int OP_W     = 4;
  localparam int HANDLE_W = 32;
  localparam int CIDX_W   = 3;
  localparam int VS_W     = 2;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_PLAY       = 4'd0;
  localparam logic [OP_W-1:0] OP_STOP       = 4'd1;
  localparam logic [OP_W-1:0] OP_PAUSE      = 4'd2;
  localparam logic [OP_W-1:0] OP_RESUME     = 4'd3;
  localparam logic [OP_W-1:0] OP_QUERY      = 4'd4;
  localparam logic [OP_W-1:0] OP_FINISH     = 4'd5;
  localparam logic [OP_W-1:0] OP_PAUSE_ALL  = 4'd6;
  localparam logic [OP_W-1:0] OP_RESUME_ALL = 4'd7;
  localparam logic [OP_W-1:0] OP_STOP_ALL   = 4'd8;

  // Voice state codes
  localparam logic [VS_W-1:0] VS_STOPPED = 2'd0;
  localparam logic [VS_W-1:0] VS_PLAYING = 2'd1;
  localparam logic [VS_W-1:0] VS_PAUSED  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture a request, clear the scan trackers
    logic rd_en;  // read the next channel entry
    logic apply;  // commit state changes and load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_last;  // the read issued now is the last channel
    logic out_free;   // the result register can take a new result
  } stat_t;

  // One result item
  typedef struct packed {
    logic [HANDLE_W-1:0] new_handle;
    logic [CIDX_W-1:0]   chosen_channel;
    logic                was_stolen;
    logic [HANDLE_W-1:0] evicted_handle;
    logic [VS_W-1:0]     voice_state;
    logic                hit;
  } res_t;

endpackage

>>> rtl/vas_if.sv
// Request and result channel interfaces of the voice allocator.
interface vas_req_if #(
  parameter int SND_W = vas_pkg::SOUND_ID_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [vas_pkg::OP_W-1:0]      opcode;
  logic [SND_W-1:0]              sound_id;
  logic                          loop_flag;
  logic [vas_pkg::HANDLE_W-1:0]  target_handle;
  logic [vas_pkg::CIDX_W-1:0]    channel_index;

  modport source (
    output valid, opcode, sound_id, loop_flag, target_handle, channel_index,
    input  ready
  );
  modport sink (
    input  valid, opcode, sound_id, loop_flag, target_handle, channel_index,
    output ready
  );
endinterface

interface vas_rsp_if ();
  logic                          valid;
  logic                          ready;
  logic [vas_pkg::HANDLE_W-1:0]  new_handle;
  logic [vas_pkg::CIDX_W-1:0]    chosen_channel;
  logic                          was_stolen;
  logic [vas_pkg::HANDLE_W-1:0]  evicted_handle;
  logic [vas_pkg::VS_W-1:0]      voice_state;
  logic                          hit;

  modport source (
    output valid, new_handle, chosen_channel, was_stolen, evicted_handle,
           voice_state, hit,
    input  ready
  );
  modport sink (
    input  valid, new_handle, chosen_channel, was_stolen, evicted_handle,
           voice_state, hit,
    output ready
  );
endinterface

>>> rtl/voice_allocator_with_stealing.sv
// Each accepted request occupies the allocator until in_chan.ready rises again:
// the controller takes the transfer in IDLE, reads each channel entry in turn in
// SCAN through the table's single read port (handle, sound id, loop flag), waits
// for the last registered read in DRAIN, and in APPLY commits the state change and
// loads the result register. The commit waits only while an earlier result still
// sits unread in the result register; a result waiting there does not block
// acceptance of the next request.
// Play takes the lowest free channel; when all are busy it replaces the oldest voice
// (smallest handle) of the same sound, else the oldest non-looping voice, else the
// oldest voice. Handles count up from 1 and skip 0 on wrap. No clearing pass is
// needed after reset.
module voice_allocator_with_stealing #(
  parameter int NUM_CHANNELS  = vas_pkg::NUM_CHANNELS_DEF,
  parameter int SOUND_ID_BITS = vas_pkg::SOUND_ID_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  vas_req_if.sink   in_chan,
  vas_rsp_if.source out_chan
);
  import vas_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  res_t  res;
  logic  out_valid;

  // Sequencing
  vas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Channel table and result
  vas_dpath #(
    .NUM_CHANNELS  (NUM_CHANNELS),
    .SOUND_ID_BITS (SOUND_ID_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_chan.opcode),
    .in_sound_id      (in_chan.sound_id),
    .in_loop_flag     (in_chan.loop_flag),
    .in_target_handle (in_chan.target_handle),
    .in_channel_index (in_chan.channel_index),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_chan.ready),
    .out_res          (res)
  );

  // Drive the result channel
  assign out_chan.valid          = out_valid;
  assign out_chan.new_handle     = res.new_handle;
  assign out_chan.chosen_channel = res.chosen_channel;
  assign out_chan.was_stolen     = res.was_stolen;
  assign out_chan.evicted_handle = res.evicted_handle;
  assign out_chan.voice_state    = res.voice_state;
  assign out_chan.hit            = res.hit;

endmodule

>>> rtl/vas_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/vas_ctrl.sv
// Controller state machine: accept, scan the channel table, drain, apply.
module vas_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  vas_pkg::stat_t stat,
  output vas_pkg::cmd_t  cmd
);
  import vas_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_APPLY = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Drive commands
  assign in_ready  = (state_r == ST_IDLE);
  assign cmd.load  = in_valid && (state_r == ST_IDLE);
  assign cmd.rd_en = (state_r == ST_SCAN);
  assign cmd.apply = (state_r == ST_APPLY) && stat.out_free;

  a_apply_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> stat.out_free)
    else $error("result committed while the result register is full");

  a_load_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_SCAN))
    else $error("accepted request did not start a scan");

  a_last_read_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && stat.scan_last) |=> (state_r == ST_DRAIN && !cmd.rd_en))
    else $error("scan did not stop after the last channel");

endmodule

>>> rtl/vas_dpath.sv
// Datapath: channel table, scan trackers, request decode and result register.
module vas_dpath #(
  parameter int NUM_CHANNELS  = vas_pkg::NUM_CHANNELS_DEF,
  parameter int SOUND_ID_BITS = vas_pkg::SOUND_ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [vas_pkg::OP_W-1:0]     in_opcode,
  input  logic [SOUND_ID_BITS-1:0]     in_sound_id,
  input  logic                         in_loop_flag,
  input  logic [vas_pkg::HANDLE_W-1:0] in_target_handle,
  input  logic [vas_pkg::CIDX_W-1:0]   in_channel_index,
  input  vas_pkg::cmd_t                cmd,
  output vas_pkg::stat_t               stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output vas_pkg::res_t                out_res
);
  import vas_pkg::*;

  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CX_W  = (CH_W > CIDX_W) ? CH_W : CIDX_W;
  localparam int RAM_W = HANDLE_W + SOUND_ID_BITS + 1;

  // Request registers
  logic [OP_W-1:0]          op_r;
  logic [SOUND_ID_BITS-1:0] snd_r;
  logic                     lp_r;
  logic [HANDLE_W-1:0]      tgt_r;
  logic [CIDX_W-1:0]        cidx_r;

  // Per-channel flags and handle counter
  logic [NUM_CHANNELS-1:0]  active_r, active_nxt;
  logic [NUM_CHANNELS-1:0]  paused_r, paused_nxt;
  logic [HANDLE_W-1:0]      last_r, last_nxt;

  // Scan pipeline
  logic [CH_W-1:0]          scan_idx_r;
  logic                     chk_vld_r;
  logic [CH_W-1:0]          chk_idx_r;
  logic [NUM_CHANNELS-1:0]  match_r;

  // Scan trackers
  logic                     free_f_r, hit_f_r, any_f_r, ss_f_r, nl_f_r;
  logic [CH_W-1:0]          free_idx_r, hit_idx_r, any_idx_r, ss_idx_r, nl_idx_r;
  logic [HANDLE_W-1:0]      any_h_r, ss_h_r, nl_h_r;

  // Result register
  logic                     out_valid_r;
  res_t                     res_r, res_nxt;

  // Channel table port signals
  logic                     ram_we;
  logic [RAM_W-1:0]         ram_wdata;
  logic [RAM_W-1:0]         ram_rdata;
  logic [HANDLE_W-1:0]      rd_handle;
  logic [SOUND_ID_BITS-1:0] rd_sound;
  logic                     rd_loop;

  // Scan compare results
  logic                     chk_act, chk_match, any_upd, ss_upd, nl_upd;

  // Apply helpers
  logic [HANDLE_W-1:0]      inc_h, next_h, evict_h;
  logic [CH_W-1:0]          play_c, cidx_c;
  logic [CX_W-1:0]          cidx_x;
  logic                     cidx_ok, hit_paused;
  logic [NUM_CHANNELS-1:0]  others;

  // Map a channel number to the three-bit result field
  function automatic logic [CIDX_W-1:0] ch3(input logic [CH_W-1:0] c);
    logic [CX_W-1:0] x;
    x = CX_W'(c);
    return x[CIDX_W-1:0];
  endfunction

  // Handle, sound id and loop flag per channel
  vas_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_CHANNELS)
  ) u_chan_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (play_c),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  assign rd_handle = ram_rdata[RAM_W-1 -: HANDLE_W];
  assign rd_sound  = ram_rdata[1 +: SOUND_ID_BITS];
  assign rd_loop   = ram_rdata[0];

  // Compare the entry read back against the trackers
  assign chk_act   = active_r[chk_idx_r];
  assign chk_match = chk_act && (tgt_r != '0) && (rd_handle == tgt_r);
  assign any_upd   = chk_act && (!any_f_r || (rd_handle < any_h_r));
  assign ss_upd    = chk_act && (rd_sound == snd_r) && (!ss_f_r || (rd_handle < ss_h_r));
  assign nl_upd    = chk_act && !rd_loop && (!nl_f_r || (rd_handle < nl_h_r));

  // Pick the play channel: free first, then same sound, non-looping, any
  always_comb begin
    priority if (free_f_r) begin
      play_c  = free_idx_r;
      evict_h = '0;
    end else if (ss_f_r) begin
      play_c  = ss_idx_r;
      evict_h = ss_h_r;
    end else if (nl_f_r) begin
      play_c  = nl_idx_r;
      evict_h = nl_h_r;
    end else begin
      play_c  = any_idx_r;
      evict_h = any_h_r;
    end
  end

  assign inc_h      = last_r + HANDLE_W'(1);
  assign next_h     = (inc_h == '0) ? HANDLE_W'(1) : inc_h;
  assign ram_wdata  = {next_h, snd_r, lp_r};
  assign cidx_x     = CX_W'(cidx_r);
  assign cidx_c     = cidx_x[CH_W-1:0];
  assign cidx_ok    = 32'(cidx_r) < 32'(NUM_CHANNELS);
  assign hit_paused = paused_r[hit_idx_r];
  assign others     = active_r & ~match_r;

  // Decode the request into state changes and a result
  always_comb begin
    active_nxt = active_r;
    paused_nxt = paused_r;
    last_nxt   = last_r;
    ram_we     = 1'b0;
    res_nxt    = '0;
    unique case (op_r)
      OP_PLAY: begin
        active_nxt[play_c]     = 1'b1;
        paused_nxt[play_c]     = 1'b0;
        last_nxt               = next_h;
        ram_we                 = cmd.apply;
        res_nxt.new_handle     = next_h;
        res_nxt.chosen_channel = ch3(play_c);
        res_nxt.was_stolen     = !free_f_r;
        res_nxt.evicted_handle = evict_h;
        res_nxt.voice_state    = VS_PLAYING;
      end
      OP_STOP, OP_PAUSE, OP_RESUME, OP_QUERY: begin
        if (hit_f_r) begin
          res_nxt.hit            = 1'b1;
          res_nxt.chosen_channel = ch3(hit_idx_r);
          priority if (op_r == OP_STOP) begin
            active_nxt[hit_idx_r] = 1'b0;
            paused_nxt[hit_idx_r] = 1'b0;
            res_nxt.voice_state   = VS_STOPPED;
          end else if (op_r == OP_PAUSE) begin
            paused_nxt[hit_idx_r] = 1'b1;
            res_nxt.voice_state   = VS_PAUSED;
          end else if (op_r == OP_RESUME) begin
            paused_nxt[hit_idx_r] = 1'b0;
            res_nxt.voice_state   = VS_PLAYING;
          end else begin
            res_nxt.voice_state   = hit_paused ? VS_PAUSED : VS_PLAYING;
          end
        end
      end
      OP_FINISH: begin
        res_nxt.chosen_channel = cidx_r;
        if (cidx_ok) begin
          res_nxt.hit        = active_r[cidx_c];
          active_nxt[cidx_c] = 1'b0;
          paused_nxt[cidx_c] = 1'b0;
        end
      end
      OP_PAUSE_ALL, OP_RESUME_ALL, OP_STOP_ALL: begin
        priority if (op_r == OP_PAUSE_ALL) begin
          paused_nxt = paused_r | others;
        end else if (op_r == OP_RESUME_ALL) begin
          paused_nxt = paused_r & ~others;
        end else begin
          active_nxt = active_r & match_r;
          paused_nxt = paused_r & match_r;
        end
        // The excepted voice is untouched, so its flags hold
        if (hit_f_r) begin
          res_nxt.hit            = 1'b1;
          res_nxt.chosen_channel = ch3(hit_idx_r);
          res_nxt.voice_state    = hit_paused ? VS_PAUSED : VS_PLAYING;
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  // Control and flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      paused_r    <= '0;
      last_r      <= '0;
      scan_idx_r  <= '0;
      chk_vld_r   <= 1'b0;
      free_f_r    <= 1'b0;
      hit_f_r     <= 1'b0;
      any_f_r     <= 1'b0;
      ss_f_r      <= 1'b0;
      nl_f_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      chk_vld_r <= cmd.rd_en;
      // Restart the scan on a new request, else advance it
      if (cmd.load) begin
        scan_idx_r <= '0;
        free_f_r   <= 1'b0;
        hit_f_r    <= 1'b0;
        any_f_r    <= 1'b0;
        ss_f_r     <= 1'b0;
        nl_f_r     <= 1'b0;
      end else begin
        if (cmd.rd_en) scan_idx_r <= scan_idx_r + CH_W'(1);
        if (chk_vld_r) begin
          if (!chk_act) free_f_r <= 1'b1;
          if (chk_match) hit_f_r <= 1'b1;
          if (any_upd) any_f_r <= 1'b1;
          if (ss_upd) ss_f_r <= 1'b1;
          if (nl_upd) nl_f_r <= 1'b1;
        end
      end
      // Commit the request
      if (cmd.apply) begin
        active_r <= active_nxt;
        paused_r <= paused_nxt;
        last_r   <= last_nxt;
      end
      // Result handshake
      if (cmd.apply) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      snd_r  <= in_sound_id;
      lp_r   <= in_loop_flag;
      tgt_r  <= in_target_handle;
      cidx_r <= in_channel_index;
    end
    chk_idx_r <= scan_idx_r;
    if (cmd.load) begin
      match_r <= '0;
    end else if (chk_vld_r) begin
      match_r[chk_idx_r] <= chk_match;
    end
    // Record first free, first match and oldest candidates
    if (chk_vld_r && !cmd.load) begin
      if (!chk_act && !free_f_r) free_idx_r <= chk_idx_r;
      if (chk_match && !hit_f_r) hit_idx_r <= chk_idx_r;
      if (any_upd) begin
        any_idx_r <= chk_idx_r;
        any_h_r   <= rd_handle;
      end
      if (ss_upd) begin
        ss_idx_r <= chk_idx_r;
        ss_h_r   <= rd_handle;
      end
      if (nl_upd) begin
        nl_idx_r <= chk_idx_r;
        nl_h_r   <= rd_handle;
      end
    end
    if (cmd.apply) res_r <= res_nxt;
  end

  assign stat.scan_last = (scan_idx_r == CH_W'(NUM_CHANNELS - 1));
  assign stat.out_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_res        = res_r;

endmodule
